// ===== src/cmx_pkg.sv =====
// ----------------------------------------------------------------------------
// cmx_pkg
// Shared types and constants of the 3x3 color matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package cmx_pkg;

    localparam int FW = 32;

    localparam logic [FW-1:0] F32_ONE  = 32'h3F80_0000;
    localparam logic [FW-1:0] F32_NZRO = 32'h8000_0000;
    localparam logic [FW-1:0] F32_INF  = 32'h7F80_0000;
    localparam logic [FW-1:0] F32_QNAN = 32'h7FC0_0000;

    // register indexes
    localparam logic [2:0] REG_R0C01  = 3'd0;
    localparam logic [2:0] REG_R0C2R1 = 3'd1;
    localparam logic [2:0] REG_R1C12  = 3'd2;
    localparam logic [2:0] REG_R2C01  = 3'd3;
    localparam logic [2:0] REG_R2C2   = 3'd4;

    typedef logic [FW-1:0] t_f32;

    // fma operands unpacked and normalized, special cases settled
    typedef struct packed {
        logic        spec;      // result is fixed
        t_f32        spec_val;
        logic        zzero;     // addend is zero
        logic        ps;
        logic        zs;
        logic [23:0] xm;
        logic [23:0] ym;
        logic [23:0] zm;
        logic signed [11:0] ep; // product exponent (lsb weight)
        logic signed [11:0] ec; // addend exponent (lsb weight)
    } t_fma_in;

endpackage : cmx_pkg

`default_nettype wire

// ===== src/cmx_fma.sv =====
// ----------------------------------------------------------------------------
// cmx_fma
// Pipelined single-precision fused multiply-add, x*y+z, round to nearest even.
// Four stages: decode, multiply, align/add, normalize/round.
// ----------------------------------------------------------------------------
`default_nettype none

module cmx_fma (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire cmx_pkg::t_f32 i_x,
    input  wire cmx_pkg::t_f32 i_y,
    input  wire cmx_pkg::t_f32 i_z,
    output cmx_pkg::t_f32      o_r
);
    import cmx_pkg::*;

    // stage 1: unpack, normalize significands and settle special values
    t_fma_in n_s1, r_s1;

    always_comb begin
        logic [7:0] xe, ye, ze;
        logic [22:0] xf, yf, zf;
        logic [23:0] xmv, ymv, zmv;
        logic [4:0] lx, ly, lz;
        logic xi, yi, zi, xz, yz;
        xe = i_x[30:23]; ye = i_y[30:23]; ze = i_z[30:23];
        xf = i_x[22:0];  yf = i_y[22:0];  zf = i_z[22:0];
        xi = (xe == 8'hFF); yi = (ye == 8'hFF); zi = (ze == 8'hFF);
        xz = (xe == 8'd0) && (xf == 23'd0);
        yz = (ye == 8'd0) && (yf == 23'd0);
        xmv = {(xe != 8'd0), xf};
        ymv = {(ye != 8'd0), yf};
        zmv = {(ze != 8'd0), zf};
        // leading zeros of denormal significands
        lx = '0; ly = '0; lz = '0;
        for (int i = 0; i < 24; i++) begin
            if (xmv[i]) lx = 5'(23 - i);
            if (ymv[i]) ly = 5'(23 - i);
            if (zmv[i]) lz = 5'(23 - i);
        end
        n_s1          = '0;
        n_s1.ps       = i_x[31] ^ i_y[31];
        n_s1.zs       = i_z[31];
        n_s1.xm       = xmv << lx;
        n_s1.ym       = ymv << ly;
        n_s1.zm       = zmv << lz;
        n_s1.ep = $signed({4'd0, (xe == 8'd0) ? 8'd1 : xe})
                + $signed({4'd0, (ye == 8'd0) ? 8'd1 : ye}) - 12'sd300
                - $signed({7'd0, lx}) - $signed({7'd0, ly});
        n_s1.ec = $signed({4'd0, (ze == 8'd0) ? 8'd1 : ze}) - 12'sd150
                - $signed({7'd0, lz});
        n_s1.zzero    = (ze == 8'd0) && (zf == 23'd0);
        n_s1.spec     = 1'b0;
        n_s1.spec_val = '0;
        if ((xi && xf != 0) || (yi && yf != 0) || (zi && zf != 0)) begin
            n_s1.spec = 1'b1; n_s1.spec_val = F32_QNAN;
        end else if (xi || yi) begin
            n_s1.spec = 1'b1;
            if (xz || yz || (zi && i_z[31] != n_s1.ps)) n_s1.spec_val = F32_QNAN;
            else n_s1.spec_val = {n_s1.ps, F32_INF[30:0]};
        end else if (zi) begin
            n_s1.spec = 1'b1; n_s1.spec_val = i_z;
        end else if (xz || yz) begin
            n_s1.spec = 1'b1;
            n_s1.spec_val = n_s1.zzero ? {n_s1.ps & n_s1.zs, 31'd0} : i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_s1 <= n_s1;
    end

    // stage 2: significand product
    t_fma_in     r_s2;
    logic [47:0] r_p2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= r_s1;
            r_p2 <= r_s1.xm * r_s1.ym;
        end
    end

    // stage 3: align the smaller term and add on a 76-bit datapath
    // both terms placed with msb at bit 74, sticky below
    logic               r_spec3;
    t_f32               r_sv3;
    logic               r_s3;
    logic [75:0]        r_sum3;
    logic signed [12:0] r_e3;
    logic               r_zero3;

    logic [75:0]        n_sum3;
    logic               n_s3;
    logic signed [12:0] n_e3;

    always_comb begin : s3
        logic [75:0] pa, za, big, sml, lost_mask;
        logic signed [12:0] epa, eza, d;
        logic bs;
        if (r_p2[47]) begin
            pa  = {1'b0, r_p2, 27'd0};
            epa = 13'(r_s2.ep) - 13'sd27;
        end else begin
            pa  = {1'b0, r_p2[46:0], 28'd0};
            epa = 13'(r_s2.ep) - 13'sd28;
        end
        za  = {1'b0, r_s2.zm, 51'd0};
        eza = 13'(r_s2.ec) - 13'sd51;
        lost_mask = '0;
        if (r_s2.zzero) begin
            big = pa; sml = '0; bs = r_s2.ps; d = '0;
        end else if ((epa > eza) || (epa == eza && pa >= za)) begin
            big = pa; sml = za; bs = r_s2.ps; d = epa - eza;
        end else begin
            big = za; sml = pa; bs = r_s2.zs; d = eza - epa; epa = eza;
        end
        if (d >= 13'sd76) begin
            sml = (sml != 0) ? 76'd1 : 76'd0;
        end else begin
            lost_mask = ~(76'hFFFF_FFFF_FFFF_FFFF_FFF << d[6:0]);
            sml = (sml >> d[6:0]) | {75'd0, |(sml & lost_mask)};
        end
        n_sum3  = (r_s2.zzero || r_s2.ps == r_s2.zs) ? big + sml : big - sml;
        n_s3    = r_s2.zzero ? r_s2.ps : bs;
        n_e3    = epa;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec3 <= r_s2.spec;
            r_sv3   <= r_s2.spec_val;
            r_s3    <= n_s3;
            r_sum3  <= n_sum3;
            r_e3    <= n_e3;
            r_zero3 <= (n_sum3 == 76'd0);
        end
    end

    // stage 4: normalize and round
    t_f32 n_r, r_r;

    always_comb begin : s4
        logic [6:0] t;
        logic signed [13:0] be, s;
        logic [75:0] q, rem, half, m;
        logic [31:0] fld, tot;
        logic [6:0] sh;
        m = r_sum3;
        t = '0;
        for (int i = 0; i < 76; i++) begin
            if (m[i]) t = 7'(i);
        end
        be = 14'(t) + 14'(r_e3) + 14'sd127;
        s  = (be >= 14'sd1) ? (14'(t) - 14'sd23) : (-14'sd149 - 14'(r_e3));
        q = '0; rem = '0; half = '0; sh = '0;
        if (s <= 0) begin
            q = m << 7'(-s);
        end else if (s >= 14'sd76) begin
            q = '0;
        end else begin
            sh   = 7'(s);
            rem  = m & ~(76'hFFFF_FFFF_FFFF_FFFF_FFF << sh);
            half = 76'd1 << (sh - 7'd1);
            q    = m >> sh;
            if (rem > half || (rem == half && q[0])) q = q + 76'd1;
        end
        fld = (be >= 14'sd1) ? 32'(be - 14'sd1) : 32'd0;
        tot = (fld << 23) + q[31:0];
        if (r_spec3) n_r = r_sv3;
        else if (r_zero3) n_r = '0;
        else if (tot >= {1'b0, F32_INF[30:0]} || be > 14'sd300)
            n_r = {r_s3, F32_INF[30:0]};
        else n_r = {r_s3, tot[30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_r <= n_r;
    end

    assign o_r = r_r;

endmodule : cmx_fma

`default_nettype wire

// ===== src/color_matrix_3x3.sv =====
// ----------------------------------------------------------------------------
// color_matrix_3x3
// 3x3 floating-point color matrix: row k = fma(ck2,c, fma(ck1,b, ck0*a)).
// ----------------------------------------------------------------------------
// structure: three 4-stage fmas in series from input transfer to output valid
// throughput: one pixel per cycle; the whole pipe advances when the output
// register is empty or being drained
// reset: synchronous active low, clears valid bits and loads the identity matrix
`default_nettype none

module color_matrix_3x3 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_chan0_in,
    input  wire logic [31:0] i_chan1_in,
    input  wire logic [31:0] i_chan2_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_chan0_out,
    output logic [31:0]      o_chan1_out,
    output logic [31:0]      o_chan2_out
);
    import cmx_pkg::*;

    localparam int LAT = 4;
    localparam int DEP = 3 * LAT;

    // coefficient registers
    t_f32 r_coef [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++)
                r_coef[i] <= (i == 0 || i == 4 || i == 8) ? F32_ONE : '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_R0C01:  begin r_coef[0] <= i_cfg_data[31:0]; r_coef[1] <= i_cfg_data[63:32]; end
                REG_R0C2R1: begin r_coef[2] <= i_cfg_data[31:0]; r_coef[3] <= i_cfg_data[63:32]; end
                REG_R1C12:  begin r_coef[4] <= i_cfg_data[31:0]; r_coef[5] <= i_cfg_data[63:32]; end
                REG_R2C01:  begin r_coef[6] <= i_cfg_data[31:0]; r_coef[7] <= i_cfg_data[63:32]; end
                REG_R2C2:   r_coef[8] <= i_cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipe advances unless the output holds an untaken result
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic [DEP-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEP-2:0], i_valid};
    end
    assign o_valid = r_vld[DEP-1];

    // delay lines for b and c to meet the later fma steps
    t_f32 r_bd [LAT];
    t_f32 r_cd [2*LAT];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bd[0] <= i_chan1_in;
            r_cd[0] <= i_chan2_in;
            for (int i = 1; i < LAT; i++) r_bd[i] <= r_bd[i-1];
            for (int i = 1; i < 2*LAT; i++) r_cd[i] <= r_cd[i-1];
        end
    end

    t_f32 w_a_in [3];
    assign w_a_in[0] = i_chan0_in;
    assign w_a_in[1] = i_chan0_in;
    assign w_a_in[2] = i_chan0_in;

    t_f32 w_r1 [3];
    t_f32 w_r2 [3];
    t_f32 w_r3 [3];

    // three fma steps per row
    for (genvar k = 0; k < 3; k++) begin : g_row
        cmx_fma u_f0 (.i_clk(i_clk), .i_en(w_en), .i_x(r_coef[3*k]),
                      .i_y(w_a_in[k]), .i_z(F32_NZRO), .o_r(w_r1[k]));
        cmx_fma u_f1 (.i_clk(i_clk), .i_en(w_en), .i_x(r_coef[3*k+1]),
                      .i_y(r_bd[LAT-1]), .i_z(w_r1[k]), .o_r(w_r2[k]));
        cmx_fma u_f2 (.i_clk(i_clk), .i_en(w_en), .i_x(r_coef[3*k+2]),
                      .i_y(r_cd[2*LAT-1]), .i_z(w_r2[k]), .o_r(w_r3[k]));
    end

    assign o_chan0_out = w_r3[0];
    assign o_chan1_out = w_r3[1];
    assign o_chan2_out = w_r3[2];

endmodule : color_matrix_3x3

`default_nettype wire

// ===== src/cmx_checker.sv =====
// ----------------------------------------------------------------------------
// cmx_checker
// Port-level checks of the color matrix handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cmx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_ready,
    input wire logic [31:0] o_chan0_out
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_chan0_out))
        else $error("output changed while stalled");

    // input side is ready whenever output is drained
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled with output draining");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule : cmx_checker

bind color_matrix_3x3 cmx_checker u_cmx_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ready(o_ready), .o_chan0_out(o_chan0_out));

`default_nettype wire

// ===== tb/sv/color_matrix_3x3_tb.sv =====
// ----------------------------------------------------------------------------
// color_matrix_3x3_tb
// Self-checking bench for the 3x3 float color matrix. An internal binary32
// fma predictor computes each row from the current coefficients; results are
// compared in order against a queue of predicted pixels, under random idling
// on both sides, a long output hold-off and several coefficient sets.
// ----------------------------------------------------------------------------
`default_nettype none

module color_matrix_3x3_tb;

    import cmx_pkg::*;

    localparam int LATENCY   = 12;
    localparam int N_RANDOM  = 930;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        t_f32 ch0;
        t_f32 ch1;
        t_f32 ch2;
    } t_pixel;

    // coefficient copy used for prediction
    t_f32 coef_m[9];

    // top set bit of a 64-bit magnitude
    function automatic int msb64(input logic [63:0] v);
        int t;
        t = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) t = i;
        return t;
    endfunction

    // round sign * m * 2^e to binary32, nearest even
    function automatic t_f32 round_f32(input logic sgn, input logic [63:0] m,
                                       input longint e);
        int t;
        longint be, s;
        logic [63:0] q, rem, half, total;
        t  = msb64(m);
        be = t + e + 127;
        s  = (be >= 1) ? t - 23 : -149 - e;
        if (s <= 0) begin
            q = m << (-s);
        end else if (s >= 64) begin
            q = '0;
        end else begin
            rem  = m & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            q    = m >> s;
            if (rem > half || (rem == half && q[0])) q++;
        end
        total = (((be >= 1) ? 64'(be - 1) : 64'd0) << 23) + q;
        if (total >= 64'(F32_INF)) return {sgn, F32_INF[30:0]};
        return {sgn, total[30:0]};
    endfunction

    // fused x*y+z, single rounding
    function automatic t_f32 fused_mac(input t_f32 x, input t_f32 y, input t_f32 z);
        logic [7:0] xe, ye, ze;
        logic [23:0] xm, ym, zm;
        logic ps, zs, xinf, yinf, zinf, bs;
        logic [63:0] p, cm, big, lil, sum;
        longint ep, ec, d;
        int lp;
        xe = x[30:23]; ye = y[30:23]; ze = z[30:23];
        xm = {1'b0, x[22:0]}; ym = {1'b0, y[22:0]}; zm = {1'b0, z[22:0]};
        ps = x[31] ^ y[31]; zs = z[31];
        xinf = (xe == 8'hFF); yinf = (ye == 8'hFF); zinf = (ze == 8'hFF);
        if ((xinf && xm != 0) || (yinf && ym != 0) || (zinf && zm != 0)) return F32_QNAN;
        if (xinf || yinf) begin
            if ((!xinf && xe == 0 && xm == 0) || (!yinf && ye == 0 && ym == 0))
                return F32_QNAN;
            if (zinf && zs != ps) return F32_QNAN;
            return {ps, F32_INF[30:0]};
        end
        if (zinf) return z;
        if (xe == 0) xe = 1; else xm[23] = 1'b1;
        if (ye == 0) ye = 1; else ym[23] = 1'b1;
        if (ze == 0) ze = 1; else zm[23] = 1'b1;
        if (xm == 0 || ym == 0) begin
            if (zm == 0) return {ps & zs, 31'd0};
            return z;
        end
        p  = 64'(xm) * 64'(ym);
        ep = longint'(xe) + longint'(ye) - 300;
        if (zm == 0) return round_f32(ps, p, ep);
        lp = 61 - msb64(p);
        p  = p << lp;
        ep = ep - lp;
        lp = 61 - msb64(64'(zm));
        cm = 64'(zm) << lp;
        ec = longint'(ze) - 150 - lp;
        if (ep > ec || (ep == ec && p >= cm)) begin
            big = p; lil = cm; bs = ps; d = ep - ec;
        end else begin
            big = cm; lil = p; bs = zs; d = ec - ep; ep = ec;
        end
        if (d >= 64) lil = 64'd1;
        else if (d > 0) lil = (lil >> d) | 64'(((lil & ((64'd1 << d) - 1)) != 0));
        if (ps == zs) begin
            sum = big + lil;
        end else begin
            sum = big - lil;
            if (sum == 0) return '0;
        end
        return round_f32(bs, sum, ep);
    endfunction

    // one output row from the current coefficients
    function automatic t_f32 matrix_row(input int k, input t_pixel px);
        t_f32 r;
        r = fused_mac(coef_m[k*3], px.ch0, F32_NZRO);
        r = fused_mac(coef_m[k*3+1], px.ch1, r);
        return fused_mac(coef_m[k*3+2], px.ch2, r);
    endfunction

    // expected pixels in order, with mismatch reporting
    class pixel_scoreboard;
        t_pixel pending[$];
        int     n_err;
        int     n_seen;

        function void note_input(t_pixel px);
            t_pixel e;
            e.ch0 = matrix_row(0, px);
            e.ch1 = matrix_row(1, px);
            e.ch2 = matrix_row(2, px);
            pending.push_back(e);
        endfunction

        function void check_output(t_pixel got);
            t_pixel e;
            n_seen++;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected pixel %h %h %h", got.ch0, got.ch1, got.ch2);
                return;
            end
            e = pending.pop_front();
            if (e.ch0 !== got.ch0 || e.ch1 !== got.ch1 || e.ch2 !== got.ch2) begin
                n_err++;
                if (n_err <= 10)
                    $display("pixel %0d mismatch: exp %h %h %h got %h %h %h", n_seen,
                             e.ch0, e.ch1, e.ch2, got.ch0, got.ch1, got.ch2);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_chan0_in;
    logic [31:0] i_chan1_in;
    logic [31:0] i_chan2_in;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_chan0_out;
    logic [31:0] o_chan1_out;
    logic [31:0] o_chan2_out;

    pixel_scoreboard sb;
    int  cyc;
    bit  quiet;        // no idling in the final part
    bit  hold_req;     // long output stall request
    int  n_in;

    color_matrix_3x3 dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("color_matrix_3x3_tb NOT OK");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        bit held;
        held = 1'b0;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !held) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                held = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && o_valid && i_ready) begin
            got.ch0 = o_chan0_out;
            got.ch1 = o_chan1_out;
            got.ch2 = o_chan2_out;
            sb.check_output(got);
        end
    end

    // one pixel transfer, with random idling ahead of it
    task automatic send_pixel(input t_pixel px);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_chan0_in <= px.ch0;
        i_chan1_in <= px.ch1;
        i_chan2_in <= px.ch2;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(px);
        n_in++;
    endtask

    // register write, block idle
    task automatic write_coef(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < REG_R2C2) begin
            coef_m[idx*2]   = val[31:0];
            coef_m[idx*2+1] = val[63:32];
        end else if (idx == REG_R2C2) begin
            coef_m[8] = val[31:0];
        end
    endtask

    // wait until every expected pixel has come out
    task automatic drain;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // random float, weighted toward edge classes
    function automatic t_f32 rand_f32();
        logic [7:0] ex;
        case ($urandom_range(0, 9))
            0: ex = 8'h00;
            1: ex = 8'hFF;
            2: ex = 8'($urandom_range(1, 20));
            3: ex = 8'($urandom_range(235, 254));
            default: ex = 8'($urandom_range(110, 140));
        endcase
        return {1'($urandom), ex, 23'($urandom)};
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        if ($urandom_range(0, 4) == 0) begin
            px.ch0 = $urandom; px.ch1 = $urandom; px.ch2 = $urandom;
        end else begin
            px.ch0 = rand_f32(); px.ch1 = rand_f32(); px.ch2 = rand_f32();
        end
        return px;
    endfunction

    task automatic load_matrix(input t_f32 m[9]);
        write_coef(REG_R0C01,  {m[1], m[0]});
        write_coef(REG_R0C2R1, {m[3], m[2]});
        write_coef(REG_R1C12,  {m[5], m[4]});
        write_coef(REG_R2C01,  {m[7], m[6]});
        write_coef(REG_R2C2,   {$urandom, m[8]});
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        t_pixel px;
        t_pixel dir[$];
        t_f32   m[9];
        sb = new();
        n_in = 0; quiet = 0; hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_chan0_in = '0; i_chan1_in = '0; i_chan2_in = '0;
        foreach (coef_m[i]) coef_m[i] = '0;
        coef_m[0] = F32_ONE; coef_m[4] = F32_ONE; coef_m[8] = F32_ONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pixels through the reset identity
        dir.push_back('{32'h0, 32'h8000_0000, 32'h0});
        dir.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001});
        dir.push_back('{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001});
        dir.push_back('{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h007F_FFFF});
        dir.push_back('{32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000});
        foreach (dir[i]) send_pixel(dir[i]);
        drain();

        // directed pixels, mostly-ones matrix: cancellation, overflow, inf-inf
        foreach (m[i]) m[i] = F32_ONE;
        m[4] = 32'hBF80_0000;
        m[8] = 32'h7F7F_FFFF;
        load_matrix(m);
        dir.delete();
        dir.push_back('{32'h3F80_0000, 32'hBF80_0000, 32'h0});
        dir.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        dir.push_back('{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h4000_0000});
        dir.push_back('{32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000});
        dir.push_back('{32'h0, 32'h0, 32'h7F80_0000});
        dir.push_back('{32'h0000_0001, 32'h8000_0001, 32'h0000_0001});
        dir.push_back('{32'h3F80_0001, 32'h3380_0000, 32'h2F80_0000});
        foreach (dir[i]) send_pixel(dir[i]);
        drain();

        // extreme coefficients: zeros, infinity, NaN, denormal
        m = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'h0000_0001,
              32'hFFFF_FFFF, 32'h8000_0001, 32'h7F7F_FFFF, 32'hFF80_0000};
        load_matrix(m);
        for (int i = 0; i < 10; i++) send_pixel(rand_pixel());
        drain();

        // random phases with a fresh matrix each
        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 9; k++)
                m[k] = (ph == 5) ? 32'h3E80_0000 + $urandom_range(0, 32'hFFFFF)
                                 : rand_f32();
            load_matrix(m);
            if (ph == 2) hold_req = 1'b1;
            if (ph == 5) quiet = 1'b1;
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                px = rand_pixel();
                send_pixel(px);
                // mid-phase sender pause until all pixels are out
                if (ph == 1 && i == 60) drain();
            end
            drain();
        end

        $display("pixels sent %0d, checked %0d, mismatches %0d", n_in, sb.n_seen,
                 sb.n_err);
        $display("covered special floats, several matrices and long output stalls");
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("color_matrix_3x3_tb OK");
        else
            $display("color_matrix_3x3_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/cmx_pkg.sv
src/cmx_fma.sv
src/color_matrix_3x3.sv
src/cmx_checker.sv
tb/sv/color_matrix_3x3_tb.sv
